FILE: rtl/acpu_pkg.sv
// ----------------------------------------------------------------------------
// acpu_pkg
// Shared constants, payload types and controller/datapath interface types for
// the 16-bit accumulator CPU core.
// ----------------------------------------------------------------------------
package acpu_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int AW        = $clog2(MEM_BYTES);
    localparam int PCW       = 13;
    localparam int DW        = 16;
    localparam int XW        = 12;
    localparam int DIV_STEPS = DW;
    localparam int CNTW      = $clog2(DIV_STEPS);

    localparam logic [PCW:0] MEM_LIMIT = (PCW+1)'(MEM_BYTES);

    // Command codes.
    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_STEP   = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FINISHED = 3'd1;
    localparam logic [2:0] ST_BAD_OP   = 3'd2;
    localparam logic [2:0] ST_BAD_ADDR = 3'd3;
    localparam logic [2:0] ST_BAD_PC   = 3'd4;

    // Opcodes.
    localparam logic [3:0] OP_LDA = 4'h0;
    localparam logic [3:0] OP_STA = 4'h1;
    localparam logic [3:0] OP_ADD = 4'h2;
    localparam logic [3:0] OP_MUL = 4'h3;
    localparam logic [3:0] OP_DIV = 4'h4;
    localparam logic [3:0] OP_MOD = 4'h5;
    localparam logic [3:0] OP_SEA = 4'hF;

    typedef struct packed {
        logic [1:0]    cmd;
        logic [DW-1:0] word;
        logic [XW-1:0] address;
    } t_in_item;

    typedef struct packed {
        logic [2:0]     status;
        logic [DW-1:0]  accumulator;
        logic [PCW-1:0] program_counter;
        logic [DW-1:0]  read_data;
    } t_out_item;

    typedef enum logic [2:0] {
        ASEL_LP,
        ASEL_IN,
        ASEL_PC,
        ASEL_X,
        ASEL_CLR
    } t_asel;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_MUL,
        ACC_SEA,
        ACC_QUO,
        ACC_REM,
        ACC_ZERO
    } t_acc_op;

    typedef struct packed {
        logic       capture;
        logic       clr_load;
        logic       append_adv;
        t_asel      asel;
        logic       lo_byte;
        logic       mem_we;
        logic       wsrc_acc;
        logic       lat_hi;
        logic       lat_lo;
        logic       ir_load;
        logic       set_halt;
        logic       set_status;
        logic [2:0] status_val;
        t_acc_op    acc_op;
        logic       div_init;
        logic       div_step;
        logic       clr_adv;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       halted;
        logic [2:0] halt_code;
        logic       lp_ok;
        logic       lp_fits;
        logic       addr_fits;
        logic       pc_done;
        logic       pc_fits;
        logic [3:0] opcode;
        logic       x_fits;
        logic       x_zero;
        logic       clr_last;
    } t_dp_stat;

    function automatic logic fits_word(input logic [PCW-1:0] a);
        logic [PCW:0] nxt;
        nxt = {1'b0, a} + (PCW+1)'(1);
        return nxt < MEM_LIMIT;
    endfunction

endpackage

FILE: rtl/acpu_dp.sv
// ----------------------------------------------------------------------------
// acpu_dp
// Datapath: architectural registers, byte memory, multiplier, iterative
// divider and the output register.
// ----------------------------------------------------------------------------
module acpu_dp import acpu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_item o_out_data
);

    logic [1:0]     r_cmd;
    logic [DW-1:0]  r_word;
    logic [XW-1:0]  r_addr;
    logic [DW-1:0]  r_acc;
    logic [PCW-1:0] r_pc;
    logic [PCW-1:0] r_lp;
    logic [PCW-1:0] r_pe;
    logic [2:0]     r_halt;
    logic [2:0]     r_res_status;
    logic [DW-1:0]  r_buf;
    logic [DW-1:0]  r_ir;
    logic [DW-1:0]  r_quo;
    logic [XW-1:0]  r_rem;
    logic [AW-1:0]  r_clr_cnt;
    logic [7:0]     r_mem_q;
    t_out_item      r_out;
    logic [7:0]     mem [MEM_BYTES];

    logic [PCW-1:0] base;
    logic [PCW-1:0] maddr;
    logic [AW-1:0]  mem_idx;
    logic [DW-1:0]  wsrc;
    logic [7:0]     wbyte;
    logic [XW-1:0]  x;
    logic [XW:0]    rem_sh;
    logic           div_ge;
    logic [XW:0]    rem_diff;
    logic [DW+XW-1:0] prod;
    logic [DW-1:0]  n_acc;
    logic [PCW-1:0] lp_next;

    assign x = r_ir[XW-1:0];

    always_comb begin
        case (i_cmd.asel)
            ASEL_LP:  base = r_lp;
            ASEL_IN:  base = {1'b0, r_addr};
            ASEL_PC:  base = r_pc;
            ASEL_X:   base = {1'b0, x};
            ASEL_CLR: base = PCW'(r_clr_cnt);
            default:  base = r_lp;
        endcase
    end

    assign maddr   = base + PCW'(i_cmd.lo_byte);
    assign mem_idx = maddr[AW-1:0];
    assign wsrc    = i_cmd.wsrc_acc ? r_acc : r_word;
    assign wbyte   = (i_cmd.asel == ASEL_CLR) ? 8'h00 :
                     (i_cmd.lo_byte ? wsrc[7:0] : wsrc[15:8]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            mem[mem_idx] <= wbyte;
        end
        r_mem_q <= mem[mem_idx];
    end

    // One restoring division step; the remainder always stays below x.
    assign rem_sh   = {r_rem, r_quo[DW-1]};
    assign div_ge   = rem_sh >= {1'b0, x};
    assign rem_diff = rem_sh - {1'b0, x};

    assign prod    = r_acc * x;
    assign lp_next = r_lp + PCW'(2);

    always_comb begin
        case (i_cmd.acc_op)
            ACC_HOLD: n_acc = r_acc;
            ACC_LOAD: n_acc = {r_buf[15:8], r_mem_q};
            ACC_ADD:  n_acc = r_acc + DW'(x);
            ACC_MUL:  n_acc = prod[DW-1:0];
            ACC_SEA:  n_acc = DW'(x);
            ACC_QUO:  n_acc = r_quo;
            ACC_REM:  n_acc = DW'(r_rem);
            ACC_ZERO: n_acc = '0;
            default:  n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_pc      <= '0;
            r_lp      <= '0;
            r_pe      <= '0;
            r_halt    <= ST_OK;
            r_clr_cnt <= '0;
        end else begin
            r_acc <= n_acc;
            if (i_cmd.clr_adv) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_cmd.clr_load) begin
                r_lp   <= '0;
                r_pe   <= '0;
                r_pc   <= '0;
                r_halt <= ST_OK;
            end
            if (i_cmd.append_adv) begin
                r_lp <= lp_next;
                r_pe <= lp_next;
            end
            if (i_cmd.ir_load) begin
                r_pc <= r_pc + PCW'(2);
            end
            if (i_cmd.set_halt) begin
                r_halt <= i_cmd.status_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd        <= i_in_data.cmd;
            r_word       <= i_in_data.word;
            r_addr       <= i_in_data.address;
            r_res_status <= ST_OK;
            r_buf        <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_res_status <= i_cmd.status_val;
            end
            if (i_cmd.lat_hi) begin
                r_buf[15:8] <= r_mem_q;
            end else if (i_cmd.lat_lo) begin
                r_buf[7:0] <= r_mem_q;
            end
        end
        if (i_cmd.ir_load) begin
            r_ir <= {r_buf[15:8], r_mem_q};
        end
        if (i_cmd.div_init) begin
            r_quo <= r_acc;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[DW-2:0], div_ge};
            r_rem <= div_ge ? rem_diff[XW-1:0] : rem_sh[XW-1:0];
        end
        if (i_cmd.out_load) begin
            r_out.status          <= r_res_status;
            r_out.accumulator     <= r_acc;
            r_out.program_counter <= r_pc;
            r_out.read_data       <= (r_cmd == CMD_READ) ? r_buf : '0;
        end
    end

    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.halted    = r_halt != ST_OK;
        o_stat.halt_code = r_halt;
        o_stat.lp_ok     = {1'b0, r_lp} <= MEM_LIMIT;
        o_stat.lp_fits   = fits_word(r_lp);
        o_stat.addr_fits = fits_word({1'b0, r_addr});
        o_stat.pc_done   = r_pc >= r_pe;
        o_stat.pc_fits   = fits_word(r_pc);
        o_stat.opcode    = r_ir[15:12];
        o_stat.x_fits    = fits_word({1'b0, x});
        o_stat.x_zero    = x == '0;
        o_stat.clr_last  = r_clr_cnt == AW'(MEM_BYTES - 1);
    end

    assign o_out_data = r_out;

endmodule

FILE: rtl/acpu_ctrl.sv
// ----------------------------------------------------------------------------
// acpu_ctrl
// Controller: sequences memory clearing, program loading, instruction
// execution and memory reads, and owns the handshakes.
// ----------------------------------------------------------------------------
module acpu_ctrl import acpu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_WR_HI,
        S_WR_LO,
        S_RD_HI,
        S_RD_LO,
        S_RD_END,
        S_FETCH_HI,
        S_FETCH_LO,
        S_FETCH_END,
        S_EXEC,
        S_DATA_HI,
        S_DATA_LO,
        S_DATA_END,
        S_ST_HI,
        S_ST_LO,
        S_DIV_RUN,
        S_DIV_END,
        S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    t_dp_cmd         cmd;

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        cmd            = '0;
        cmd.asel       = ASEL_LP;
        cmd.acc_op     = ACC_HOLD;
        cmd.status_val = ST_OK;
        case (r_state)
            S_CLEAR: begin
                cmd.asel    = ASEL_CLR;
                cmd.mem_we  = 1'b1;
                cmd.clr_adv = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.cmd)
                    CMD_BEGIN: begin
                        cmd.clr_load = 1'b1;
                        n_state      = S_DONE;
                    end
                    CMD_APPEND: begin
                        if (i_stat.lp_ok && i_stat.lp_fits) begin
                            n_state = S_WR_HI;
                        end else begin
                            // Past the end of memory the word is dropped.
                            cmd.append_adv = i_stat.lp_ok;
                            n_state        = S_DONE;
                        end
                    end
                    CMD_STEP: begin
                        if (i_stat.halted) begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = i_stat.halt_code;
                            n_state        = S_DONE;
                        end else if (i_stat.pc_done) begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = ST_FINISHED;
                            n_state        = S_DONE;
                        end else if (!i_stat.pc_fits) begin
                            cmd.set_status = 1'b1;
                            cmd.set_halt   = 1'b1;
                            cmd.status_val = ST_BAD_PC;
                            n_state        = S_DONE;
                        end else begin
                            n_state = S_FETCH_HI;
                        end
                    end
                    CMD_READ: begin
                        n_state = i_stat.addr_fits ? S_RD_HI : S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_WR_HI: begin
                cmd.asel   = ASEL_LP;
                cmd.mem_we = 1'b1;
                n_state    = S_WR_LO;
            end
            S_WR_LO: begin
                cmd.asel       = ASEL_LP;
                cmd.lo_byte    = 1'b1;
                cmd.mem_we     = 1'b1;
                cmd.append_adv = 1'b1;
                n_state        = S_DONE;
            end
            S_RD_HI: begin
                cmd.asel = ASEL_IN;
                n_state  = S_RD_LO;
            end
            S_RD_LO: begin
                cmd.asel    = ASEL_IN;
                cmd.lo_byte = 1'b1;
                cmd.lat_hi  = 1'b1;
                n_state     = S_RD_END;
            end
            S_RD_END: begin
                // The low byte arrives in the cycle after its address.
                cmd.asel   = ASEL_IN;
                cmd.lat_lo = 1'b1;
                n_state    = S_DONE;
            end
            S_FETCH_HI: begin
                cmd.asel = ASEL_PC;
                n_state  = S_FETCH_LO;
            end
            S_FETCH_LO: begin
                cmd.asel    = ASEL_PC;
                cmd.lo_byte = 1'b1;
                cmd.lat_hi  = 1'b1;
                n_state     = S_FETCH_END;
            end
            S_FETCH_END: begin
                cmd.ir_load = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (i_stat.opcode)
                    OP_LDA: begin
                        if (i_stat.x_fits) begin
                            n_state = S_DATA_HI;
                        end else begin
                            cmd.set_status = 1'b1;
                            cmd.set_halt   = 1'b1;
                            cmd.status_val = ST_BAD_ADDR;
                        end
                    end
                    OP_STA: begin
                        if (i_stat.x_fits) begin
                            n_state = S_ST_HI;
                        end else begin
                            cmd.set_status = 1'b1;
                            cmd.set_halt   = 1'b1;
                            cmd.status_val = ST_BAD_ADDR;
                        end
                    end
                    OP_ADD: cmd.acc_op = ACC_ADD;
                    OP_MUL: cmd.acc_op = ACC_MUL;
                    OP_SEA: cmd.acc_op = ACC_SEA;
                    OP_DIV, OP_MOD: begin
                        if (i_stat.x_zero) begin
                            cmd.acc_op = ACC_ZERO;
                        end else begin
                            cmd.div_init = 1'b1;
                            n_cnt        = '0;
                            n_state      = S_DIV_RUN;
                        end
                    end
                    default: begin
                        cmd.set_status = 1'b1;
                        cmd.set_halt   = 1'b1;
                        cmd.status_val = ST_BAD_OP;
                    end
                endcase
            end
            S_DATA_HI: begin
                cmd.asel = ASEL_X;
                n_state  = S_DATA_LO;
            end
            S_DATA_LO: begin
                cmd.asel    = ASEL_X;
                cmd.lo_byte = 1'b1;
                cmd.lat_hi  = 1'b1;
                n_state     = S_DATA_END;
            end
            S_DATA_END: begin
                cmd.acc_op = ACC_LOAD;
                n_state    = S_DONE;
            end
            S_ST_HI: begin
                cmd.asel     = ASEL_X;
                cmd.mem_we   = 1'b1;
                cmd.wsrc_acc = 1'b1;
                n_state      = S_ST_LO;
            end
            S_ST_LO: begin
                cmd.asel     = ASEL_X;
                cmd.lo_byte  = 1'b1;
                cmd.mem_we   = 1'b1;
                cmd.wsrc_acc = 1'b1;
                n_state      = S_DONE;
            end
            S_DIV_RUN: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(DIV_STEPS - 1)) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: begin
                cmd.acc_op = (i_stat.opcode == OP_DIV) ? ACC_QUO : ACC_REM;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;

    assign n_out_valid = cmd.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/accumulator_cpu16_core.sv
// ----------------------------------------------------------------------------
// accumulator_cpu16_core
// 16-bit accumulator CPU with a byte-wide big-endian memory, one transaction at a time.
// Begin resets the load pointer, append writes a word as two bytes (or drops it past the
// end of memory), read fetches two bytes, and step fetches and executes one instruction;
// divide and modulo run through the restoring divider.
// The next transaction is accepted in the cycle after its predecessor's result is
// registered; a result not yet taken holds the following one back at completion.
// Reset is synchronous; the memory is then cleared one byte a cycle, all 4096 bytes.
// ----------------------------------------------------------------------------
module accumulator_cpu16_core import acpu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    acpu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    acpu_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_out_data (o_out_data)
    );

endmodule
